[hw/rtl/md5_pkg.sv]
// Shared types, constants and round tables for the MD5 digest block.
// Depends on nothing; imported by every module of the block.
package md5_pkg;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [2:0] WORD_BYTES = 3'd4;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] LAST_POS   = 6'h3f;
  localparam logic [5:0] LAST_ROUND = 6'd63;

  // Input word: up to four message bytes, first byte in bits 7:0
  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_word;
  } md5_in_t;

  // Result word: half of the digest
  typedef struct packed {
    logic [63:0] digest_part;
    logic        last_part;
  } md5_out_t;

  // Sequencer states of the top level
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BYTE,
    ST_PAD80,
    ST_PADZ,
    ST_LEN,
    ST_COMP,
    ST_OUT0,
    ST_OUT1
  } md5_state_t;

  // Phases of the compression unit
  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_RUN,
    CORE_FIN
  } md5_core_state_t;

  // Commands to the compression unit
  typedef struct packed {
    logic start;
    logic init;
  } md5_core_cmd_t;

  // Write commands to the block buffer
  typedef struct packed {
    logic        byte_we;
    logic [5:0]  pos;
    logic [7:0]  byte_val;
    logic        len_we;
    logic [63:0] len;
  } md5_buf_cmd_t;

  function automatic logic [31:0] round_const(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Left-rotate amount, by round group and round within a group of four
  function automatic logic [4:0] rot_amount(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

endpackage

[hw/rtl/md5_buf.sv]
// Block buffer: sixteen message words, written a byte at a time or as the length pair.
// Depends on md5_pkg.
module md5_buf (
  input  logic                 clk,
  input  md5_pkg::md5_buf_cmd_t cmd,
  input  logic [3:0]           rd_idx,
  output logic [31:0]          rd_word
);
  import md5_pkg::*;

  logic [3:0][7:0] words [16];

  // Write one byte lane, or the 64-bit bit length into words 14 and 15
  always_ff @(posedge clk) begin
    if (cmd.byte_we) begin
      words[cmd.pos[5:2]][cmd.pos[1:0]] <= cmd.byte_val;
    end
    if (cmd.len_we) begin
      words[14] <= cmd.len[31:0];
      words[15] <= cmd.len[63:32];
    end
  end

  // Register the addressed word for the round that runs next cycle
  always_ff @(posedge clk) begin
    rd_word <= words[rd_idx];
  end

endmodule

[hw/rtl/md5_core.sv]
// Compression unit: one MD5 round per cycle over a shared round datapath,
// plus the chaining words. Depends on md5_pkg.
module md5_core (
  input  logic                  clk,
  input  logic                  rst,
  input  md5_pkg::md5_core_cmd_t cmd,
  output logic [3:0]            word_idx,
  input  logic [31:0]           word,
  output logic                  done,
  output logic [3:0][31:0]      chain
);
  import md5_pkg::*;

  md5_core_state_t state, state_next;
  logic [5:0]  rnd;
  logic [5:0]  rnd_ahead;
  logic [31:0] a, b, c, d;
  logic [31:0] f, t, rot_t;
  logic [63:0] rot_wide;
  logic [3:0]  j4;

  // Address the message word of the round that runs next cycle
  always_comb begin
    rnd_ahead = (state == CORE_RUN) ? rnd + 6'd1 : 6'd0;
    j4        = rnd_ahead[3:0];
    case (rnd_ahead[5:4])
      2'd0:    word_idx = j4;
      2'd1:    word_idx = 4'((j4 << 2) + j4 + 4'd1);
      2'd2:    word_idx = 4'((j4 << 1) + j4 + 4'd5);
      default: word_idx = 4'((j4 << 3) - j4);
    endcase
  end

  // Round function
  always_comb begin
    case (rnd[5:4])
      2'd0:    f = d ^ (b & (c ^ d));
      2'd1:    f = c ^ (d & (b ^ c));
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    t        = a + f + word + round_const(rnd);
    rot_wide = {t, t} << rot_amount(rnd);
    rot_t    = rot_wide[63:32];
  end

  // Phase sequencing
  always_comb begin
    state_next = state;
    case (state)
      CORE_IDLE: if (cmd.start) state_next = CORE_RUN;
      CORE_RUN:  if (rnd == LAST_ROUND) state_next = CORE_FIN;
      CORE_FIN:  state_next = CORE_IDLE;
      default:   state_next = CORE_IDLE;
    endcase
  end

  assign done = (state == CORE_FIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CORE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working variables: load, rotate through the rounds
  always_ff @(posedge clk) begin
    if (state == CORE_IDLE && cmd.start) begin
      a   <= chain[0];
      b   <= chain[1];
      c   <= chain[2];
      d   <= chain[3];
      rnd <= '0;
    end else if (state == CORE_RUN) begin
      a   <= d;
      d   <= c;
      c   <= b;
      b   <= b + rot_t;
      rnd <= rnd + 6'd1;
    end
  end

  // Chaining words: reset values, or fold in the finished block
  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      chain <= {INIT_D, INIT_C, INIT_B, INIT_A};
    end else if (state == CORE_FIN) begin
      chain[0] <= chain[0] + a;
      chain[1] <= chain[1] + b;
      chain[2] <= chain[2] + c;
      chain[3] <= chain[3] + d;
    end
  end

endmodule

[hw/rtl/md5_message_digest.sv]
// MD5 digest block top level: byte packer, padding sequencer, bit counter.
// Depends on md5_pkg, md5_buf and md5_core.
//
// Usage:
//   msg channel (msg_valid/msg_ready/msg_word) takes message words of up to
//   four bytes, first byte in bits 7:0; byte_count below four only on the
//   word marked last_word (counts 5 to 7 act as 4).
//   dig channel (dig_valid/dig_ready/dig_part) returns the digest as two
//   words after each last word: bytes 0..7 first, then bytes 8..15 with
//   last_part set.
// Timing:
//   Each accepted word is written into the block buffer byte by byte.
//   Every full block is compressed in the compression unit, one round per
//   cycle. The last word packs padding one byte per cycle (up to 64),
//   pausing for full blocks, runs one or two more blocks and offers the
//   first digest word. msg_ready is high only when the sequencer is idle.
// Reset and stall:
//   rst (synchronous) loads the standard chaining values and clears the bit
//   count and fill position. While dig_ready is low the digest word holds;
//   no new message word is taken until both digest words are delivered,
//   after which the block re-initializes for the next message.
module md5_message_digest (
  input  logic              clk,
  input  logic              rst,
  input  logic              msg_valid,
  output logic              msg_ready,
  input  md5_pkg::md5_in_t  msg_word,
  output logic              dig_valid,
  input  logic              dig_ready,
  output md5_pkg::md5_out_t dig_part
);
  import md5_pkg::*;

  md5_state_t    state, state_next;
  md5_state_t    ret, ret_next;
  logic [3:0][7:0] wd;
  logic [2:0]    cnt;
  logic          last;
  logic [2:0]    idx;
  logic [5:0]    fill;
  logic [63:0]   bit_count;

  md5_buf_cmd_t  buf_cmd;
  md5_core_cmd_t core_cmd;
  logic [3:0]    word_idx;
  logic [31:0]   rd_word;
  logic          core_done;
  logic [3:0][31:0] chain;
  logic          put;
  logic          msg_byte;
  logic          wrap;

  md5_buf u_buf (
    .clk     (clk),
    .cmd     (buf_cmd),
    .rd_idx  (word_idx),
    .rd_word (rd_word)
  );

  md5_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cmd      (core_cmd),
    .word_idx (word_idx),
    .word     (rd_word),
    .done     (core_done),
    .chain    (chain)
  );

  assign msg_ready = (state == ST_IDLE);
  assign dig_valid = (state == ST_OUT0) || (state == ST_OUT1);
  assign dig_part.digest_part = (state == ST_OUT1) ? {chain[3], chain[2]}
                                                   : {chain[1], chain[0]};
  assign dig_part.last_part   = (state == ST_OUT1);
  assign wrap = (fill == LAST_POS);

  // Sequence bytes, padding, length and compressions
  always_comb begin
    state_next       = state;
    ret_next         = ret;
    put              = 1'b0;
    msg_byte         = 1'b0;
    buf_cmd.byte_we  = 1'b0;
    buf_cmd.pos      = fill;
    buf_cmd.byte_val = '0;
    buf_cmd.len_we   = 1'b0;
    buf_cmd.len      = bit_count;
    core_cmd.start   = 1'b0;
    core_cmd.init    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (msg_valid) state_next = ST_BYTE;
      end
      ST_BYTE: begin
        if (idx == cnt) begin
          state_next = last ? ST_PAD80 : ST_IDLE;
        end else begin
          put              = 1'b1;
          msg_byte         = 1'b1;
          buf_cmd.byte_val = wd[idx[1:0]];
          ret_next         = ST_BYTE;
        end
      end
      ST_PAD80: begin
        put              = 1'b1;
        buf_cmd.byte_val = PAD_BYTE;
        ret_next         = ST_PADZ;
        state_next       = ST_PADZ;
      end
      ST_PADZ: begin
        if (fill == LEN_POS) begin
          state_next = ST_LEN;
        end else begin
          put      = 1'b1;
          ret_next = ST_PADZ;
        end
      end
      ST_LEN: begin
        buf_cmd.len_we = 1'b1;
        core_cmd.start = 1'b1;
        ret_next       = ST_OUT0;
        state_next     = ST_COMP;
      end
      ST_COMP: begin
        if (core_done) state_next = ret;
      end
      ST_OUT0: begin
        if (dig_ready) state_next = ST_OUT1;
      end
      ST_OUT1: begin
        if (dig_ready) begin
          core_cmd.init = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    buf_cmd.byte_we = put;
    // A full block goes to compression before anything else
    if (put && wrap) begin
      core_cmd.start = 1'b1;
      state_next     = ST_COMP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (msg_valid && msg_ready) begin
      wd   <= msg_word.data_word;
      cnt  <= (msg_word.byte_count > WORD_BYTES) ? WORD_BYTES : msg_word.byte_count;
      last <= msg_word.last_word;
    end
  end

  // Advance byte index, fill position and bit count
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      fill      <= '0;
      bit_count <= '0;
    end else begin
      if (msg_valid && msg_ready) begin
        idx <= '0;
      end else if (msg_byte) begin
        idx <= idx + 3'd1;
      end
      if (core_cmd.init) begin
        fill <= '0;
      end else if (put) begin
        fill <= fill + 6'd1;
      end
      if (core_cmd.init) begin
        bit_count <= '0;
      end else if (msg_byte) begin
        bit_count <= bit_count + 64'd8;
      end
    end
  end

  // The length is written only when the fill position reaches the length field
  a_out_after_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LEN) |-> (fill == LEN_POS))
    else $error("length written at wrong fill position");

  // Input stays closed while a digest word is offered
  a_no_accept_on_out: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> !msg_ready)
    else $error("input open while digest pending");

  // Second digest word restarts the message state
  a_reinit: assert property (@(posedge clk) disable iff (rst)
    (dig_valid && dig_ready && dig_part.last_part) |=>
      (fill == '0 && bit_count == '0 && chain[0] == INIT_A && state == ST_IDLE))
    else $error("state not re-initialized after digest");

  // Compression starts only on a full block or the length block
  a_start_full: assert property (@(posedge clk) disable iff (rst)
    core_cmd.start |-> (wrap || state == ST_LEN))
    else $error("compression started on a partial block");

endmodule
